[rtl/core/crc_pkg.sv]
package crc_pkg;

   // Payload widths
   localparam int FUNC_W     = 2;
   localparam int COORD_W    = 20;
   localparam int RADIUS_W   = 19;
   localparam int CHAR_W     = 8;
   localparam int CELL_IDX_W = 9;
   localparam int STATUS_W   = 2;

   // CSR port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 10;
   localparam int SIZE_W      = 10;

   localparam logic [CSR_INDEX_W-1:0] CSR_CANVAS_WIDTH    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CANVAS_HEIGHT   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BACKGROUND_CHAR = 2'd2;

   localparam logic [SIZE_W-1:0] RESET_CANVAS_WIDTH    = 10'd1;
   localparam logic [SIZE_W-1:0] RESET_CANVAS_HEIGHT   = 10'd1;
   localparam logic [CHAR_W-1:0] RESET_BACKGROUND_CHAR = 8'd32;

   // Canvas geometry defaults
   localparam int DEFAULT_MAX_WIDTH  = 512;
   localparam int DEFAULT_MAX_HEIGHT = 512;

   // Function codes
   localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd0;
   localparam logic [FUNC_W-1:0] FN_DRAW  = 2'd1;
   localparam logic [FUNC_W-1:0] FN_READ  = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ZERO_RADIUS = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OUTSIDE     = 2'd2;

   // Fixed point: Q.8 deltas, 21 bits signed covers x*256 - cx for x < 1024
   localparam int FRAC_W  = 8;
   localparam int DELTA_W = 21;
   localparam int PROD_W  = 2 * DELTA_W;
   localparam int SQ_W    = 40;
   localparam int D2_W    = SQ_W + 1;

   localparam logic signed [DELTA_W-1:0] ONE_Q8 = 21'sd256;

endpackage

[rtl/core/crc_ram.sv]
module crc_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 262144,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/circle_raster_canvas.sv]
// Channel | Dir | Handshake          | Payload
// --------+-----+--------------------+-------------------------------------------
// req     | in  | req_valid/req_stall| func, filled, center_x/y, radius, draw_char,
//         |     |                    | read_col, read_row
// rsp     | out | rsp_valid/rsp_stall| cell_char, status
// csr     | in  | csr_valid/csr_ready| csr_index, csr_data
//
// One word at a time. Clear: sweeps the whole store, one canvas RAM write per
// cycle. Draw: the single squarer does r^2, (r-1)^2, then dy^2 once per row
// and dx^2 once per pixel. Read: through the registered RAM read. Zero radius
// and bad reads go straight to the response.
// Synchronous active-high reset clears control only; canvas holds garbage
// until cleared or drawn. req_stall is high while an item is in flight; a
// finished word waits in the rsp register, so a stalled rsp side only holds
// the block once the next result is ready.
module circle_raster_canvas #(
   parameter int MAX_WIDTH  = crc_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = crc_pkg::DEFAULT_MAX_HEIGHT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [crc_pkg::FUNC_W-1:0]             req_func,
   input  logic                                   req_filled,
   input  logic signed [crc_pkg::COORD_W-1:0]     req_center_x,
   input  logic signed [crc_pkg::COORD_W-1:0]     req_center_y,
   input  logic [crc_pkg::RADIUS_W-1:0]           req_radius,
   input  logic [crc_pkg::CHAR_W-1:0]             req_draw_char,
   input  logic [crc_pkg::CELL_IDX_W-1:0]         req_read_col,
   input  logic [crc_pkg::CELL_IDX_W-1:0]         req_read_row,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [crc_pkg::CHAR_W-1:0]             rsp_cell_char,
   output logic [crc_pkg::STATUS_W-1:0]           rsp_status,
   // register write channel
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [crc_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [crc_pkg::CSR_DATA_W-1:0]         csr_data
);

   import crc_pkg::*;

   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
   localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(MAX_WIDTH);
   // size caps, never above what the 10-bit size registers can hold
   localparam logic [SIZE_W-1:0] W_CAP = (MAX_WIDTH  > 1023) ? 10'd1023 : SIZE_W'(MAX_WIDTH);
   localparam logic [SIZE_W-1:0] H_CAP = (MAX_HEIGHT > 1023) ? 10'd1023 : SIZE_W'(MAX_HEIGHT);

   // sequencer
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CLR   = 4'd1;
   localparam logic [3:0] S_R2    = 4'd2;
   localparam logic [3:0] S_RI2   = 4'd3;
   localparam logic [3:0] S_ROW   = 4'd4;
   localparam logic [3:0] S_PIX   = 4'd5;
   localparam logic [3:0] S_DRAIN = 4'd6;
   localparam logic [3:0] S_RD    = 4'd7;
   localparam logic [3:0] S_DONE  = 4'd8;

   logic [3:0] state_ff, state_in;

   // configuration
   logic [SIZE_W-1:0] width_ff, width_in;
   logic [SIZE_W-1:0] height_ff, height_in;
   logic [CHAR_W-1:0] bg_ff, bg_in;
   logic [SIZE_W-1:0] w_eff, h_eff;

   // item fields
   logic [FUNC_W-1:0]          func_ff, func_in;
   logic                       fill_ff, fill_in;
   logic signed [COORD_W-1:0]  cx_ff, cx_in;
   logic signed [COORD_W-1:0]  cy_ff, cy_in;
   logic [RADIUS_W-1:0]        r_ff, r_in;
   logic [CHAR_W-1:0]          char_ff, char_in;
   logic [STATUS_W-1:0]        status_ff, status_in;

   // sweep counters
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic [ADDR_W-1:0] rd_addr_ff, rd_addr_in;
   logic [ADDR_W-1:0] row_base_ff, row_base_in;
   logic [SIZE_W-1:0] x_ff, x_in;
   logic [SIZE_W-1:0] y_ff, y_in;

   // squarer and distance terms
   logic signed [DELTA_W-1:0] dx, dy, r_ext, ri, mul_a;
   logic signed [PROD_W-1:0]  prod;
   logic [SQ_W-1:0]           sq;
   logic [SQ_W-1:0]           r2_ff, r2_in;
   logic [SQ_W-1:0]           ri2_ff, ri2_in;
   logic [SQ_W-1:0]           dy2_ff, dy2_in;
   logic [SQ_W-1:0]           dx2_ff, dx2_in;
   logic [D2_W-1:0]           d2;
   logic                      thin;

   // pixel write stage
   logic              pix_vld_ff, pix_vld_in;
   logic [ADDR_W-1:0] pix_addr_ff, pix_addr_in;
   logic              hit;

   // canvas RAM
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [CHAR_W-1:0] ram_wdata;
   logic [CHAR_W-1:0] ram_rdata;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]   rsp_char_ff, rsp_char_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic req_take;
   logic rsp_free;
   logic rd_outside;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // zero reads as 1, oversize clamps to the store
   assign w_eff = (width_ff == '0)  ? 10'd1 : ((width_ff > W_CAP)  ? W_CAP : width_ff);
   assign h_eff = (height_ff == '0) ? 10'd1 : ((height_ff > H_CAP) ? H_CAP : height_ff);

   assign rd_outside = ({1'b0, req_read_col} >= w_eff) || ({1'b0, req_read_row} >= h_eff);

   // register writes
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      bg_in     = bg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CANVAS_WIDTH:    width_in  = csr_data;
            CSR_CANVAS_HEIGHT:   height_in = csr_data;
            CSR_BACKGROUND_CHAR: bg_in     = csr_data[CHAR_W-1:0];
            default: ;
         endcase
      end
   end

   // Q.8 deltas: pixel (x,y) sits at (x*256, y*256)
   assign dx    = $signed({3'b000, x_ff, 8'd0}) - $signed({cx_ff[COORD_W-1], cx_ff});
   assign dy    = $signed({3'b000, y_ff, 8'd0}) - $signed({cy_ff[COORD_W-1], cy_ff});
   assign r_ext = $signed({2'b00, r_ff});
   assign ri    = r_ext - ONE_Q8;
   assign thin  = (r_ff < RADIUS_W'(256));

   // the one shared squarer
   always_comb begin
      case (state_ff)
         S_R2:    mul_a = r_ext;
         S_RI2:   mul_a = ri;
         S_ROW:   mul_a = dy;
         default: mul_a = dx;
      endcase
   end

   assign prod = mul_a * mul_a;
   assign sq   = prod[SQ_W-1:0];

   // second stage: sum and coverage test, write on hit
   assign d2  = {1'b0, dx2_ff} + {1'b0, dy2_ff};
   assign hit = pix_vld_ff && (d2 <= {1'b0, r2_ff}) &&
                (fill_ff || thin || (d2 > {1'b0, ri2_ff}));

   always_comb begin
      if (state_ff == S_CLR) begin
         ram_we    = 1'b1;
         ram_waddr = clr_addr_ff;
         ram_wdata = bg_ff;
      end else begin
         ram_we    = hit;
         ram_waddr = pix_addr_ff;
         ram_wdata = char_ff;
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      fill_in       = fill_ff;
      cx_in         = cx_ff;
      cy_in         = cy_ff;
      r_in          = r_ff;
      char_in       = char_ff;
      status_in     = status_ff;
      clr_addr_in   = clr_addr_ff;
      rd_addr_in    = rd_addr_ff;
      row_base_in   = row_base_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      r2_in         = r2_ff;
      ri2_in        = ri2_ff;
      dy2_in        = dy2_ff;
      dx2_in        = dx2_ff;
      pix_vld_in    = 1'b0;
      pix_addr_in   = pix_addr_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_char_in   = rsp_char_ff;
      rsp_status_in = rsp_status_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               func_in   = req_func;
               fill_in   = req_filled;
               cx_in     = req_center_x;
               cy_in     = req_center_y;
               r_in      = req_radius;
               char_in   = req_draw_char;
               status_in = STATUS_OK;
               case (req_func)
                  FN_CLEAR: begin
                     clr_addr_in = '0;
                     state_in    = S_CLR;
                  end
                  FN_DRAW: begin
                     if (req_radius == '0) begin
                        status_in = STATUS_ZERO_RADIUS;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_R2;
                     end
                  end
                  FN_READ: begin
                     if (rd_outside) begin
                        status_in = STATUS_OUTSIDE;
                        state_in  = S_DONE;
                     end else begin
                        rd_addr_in = ADDR_W'(int'(req_read_row) * MAX_WIDTH
                                             + int'(req_read_col));
                        state_in   = S_RD;
                     end
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_CLR: begin
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = S_DONE;
            end
         end
         S_R2: begin
            r2_in    = sq;
            state_in = S_RI2;
         end
         S_RI2: begin
            ri2_in      = sq;
            y_in        = '0;
            row_base_in = '0;
            state_in    = S_ROW;
         end
         S_ROW: begin
            dy2_in   = sq;
            x_in     = '0;
            state_in = S_PIX;
         end
         S_PIX: begin
            dx2_in      = sq;
            pix_vld_in  = 1'b1;
            pix_addr_in = row_base_ff + ADDR_W'(x_ff);
            if (x_ff == w_eff - 10'd1) begin
               if (y_ff == h_eff - 10'd1) begin
                  state_in = S_DRAIN;
               end else begin
                  y_in        = y_ff + 10'd1;
                  row_base_in = row_base_ff + ROW_STEP;
                  state_in    = S_ROW;
               end
            end else begin
               x_in = x_ff + 10'd1;
            end
         end
         S_DRAIN: begin
            // last pixel commits this cycle
            state_in = S_DONE;
         end
         S_RD: begin
            // RAM captures rd_addr_ff; data is stable from S_DONE on
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_char_in   = (func_ff == FN_READ && status_ff == STATUS_OK) ?
                               ram_rdata : '0;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         width_ff     <= RESET_CANVAS_WIDTH;
         height_ff    <= RESET_CANVAS_HEIGHT;
         bg_ff        <= RESET_BACKGROUND_CHAR;
         pix_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         bg_ff        <= bg_in;
         pix_vld_ff   <= pix_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      fill_ff       <= fill_in;
      cx_ff         <= cx_in;
      cy_ff         <= cy_in;
      r_ff          <= r_in;
      char_ff       <= char_in;
      status_ff     <= status_in;
      clr_addr_ff   <= clr_addr_in;
      rd_addr_ff    <= rd_addr_in;
      row_base_ff   <= row_base_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      r2_ff         <= r2_in;
      ri2_ff        <= ri2_in;
      dy2_ff        <= dy2_in;
      dx2_ff        <= dx2_in;
      pix_addr_ff   <= pix_addr_in;
      rsp_char_ff   <= rsp_char_in;
      rsp_status_ff <= rsp_status_in;
   end

   crc_ram #(
      .WIDTH  (CHAR_W),
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_canvas (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (rd_addr_ff),
      .rd_data (ram_rdata)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_cell_char = rsp_char_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

[bench/circle_raster_canvas_tb.sv]
`timescale 1ns / 100ps

// Bench for the circle raster canvas.
// A directed table (typed answers where they are obvious, model answers elsewhere)
// runs first. Random phases at several canvas sizes follow. Every response word is
// checked against its typed answer or a shadow canvas that tracks each accepted request.
module circle_raster_canvas_tb;
   import crc_pkg::*;

   localparam int CLK_PERIOD      = 10;
   localparam int CANVAS_COLS     = DEFAULT_MAX_WIDTH;
   localparam int CANVAS_ROWS     = DEFAULT_MAX_HEIGHT;
   localparam int CANVAS_CELLS    = CANVAS_COLS * CANVAS_ROWS;
   localparam int Q8_ONE          = 256;
   localparam int MAX_GAP         = 4;
   // longer than two of the slowest draws at the last phase's canvas size
   localparam int HOLD_OFF_CYCLES = 2000;
   localparam int DRAIN_CYCLES    = 16;
   localparam int RANDOM_PHASES   = 4;
   localparam int ITEMS_PER_PHASE = 18;
   // Two full clears dominate the run; everything else works on small or narrow
   // canvases, so the timeout leaves a wide margin.
   localparam longint TIMEOUT_NS  = 30_000_000;

   // func code 3 has no name in the package; the block treats it as a no-op
   localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

   typedef struct packed {
      logic [FUNC_W-1:0]          func;
      logic                       filled;
      logic signed [COORD_W-1:0]  center_x;
      logic signed [COORD_W-1:0]  center_y;
      logic [RADIUS_W-1:0]        radius;
      logic [CHAR_W-1:0]          draw_char;
      logic [CELL_IDX_W-1:0]      read_col;
      logic [CELL_IDX_W-1:0]      read_row;
   } canvas_cmd_type;

   typedef struct packed {
      logic [CHAR_W-1:0]   char_val;
      logic [STATUS_W-1:0] status;
   } cell_word_type;

   // Directed table rows: a register write, a request with a typed answer,
   // or a request answered by the shadow canvas.
   typedef enum logic [1:0] {
      PLAN_CSR,
      PLAN_KNOWN,
      PLAN_MODEL
   } plan_kind_type;

   typedef struct packed {
      plan_kind_type           kind;
      logic [CSR_INDEX_W-1:0]  csr_idx;
      logic [CSR_DATA_W-1:0]   csr_val;
      canvas_cmd_type          cmd;
      cell_word_type           want;
   } plan_row_type;

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   logic [FUNC_W-1:0]            req_func;
   logic                         req_filled;
   logic signed [COORD_W-1:0]    req_center_x;
   logic signed [COORD_W-1:0]    req_center_y;
   logic [RADIUS_W-1:0]          req_radius;
   logic [CHAR_W-1:0]            req_draw_char;
   logic [CELL_IDX_W-1:0]        req_read_col;
   logic [CELL_IDX_W-1:0]        req_read_row;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic [CHAR_W-1:0]            rsp_cell_char;
   logic [STATUS_W-1:0]          rsp_status;
   logic                         csr_valid;
   logic                         csr_ready;
   logic [CSR_INDEX_W-1:0]       csr_index;
   logic [CSR_DATA_W-1:0]        csr_data;

   // Shadow copy of the block: the canvas store and the three registers
   logic [CHAR_W-1:0]  shadow_canvas [CANVAS_CELLS];
   logic [SIZE_W-1:0]  cfg_width;
   logic [SIZE_W-1:0]  cfg_height;
   logic [CHAR_W-1:0]  cfg_bg;

   // Response words still owed by the block, oldest first
   cell_word_type awaited_words [$];

   int  fail_count = 0;
   bit  no_idle = 1'b0;          // both sides run flat out while set
   bit  hold_off_request = 1'b0; // asks the receiver for one long stall
   int  hold_off_done = 0;

   int  clears_sent = 0, draws_sent = 0, zero_radius_sent = 0;
   int  reads_sent = 0, outside_sent = 0, unused_sent = 0, csr_writes = 0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   circle_raster_canvas #(
      .MAX_WIDTH  (CANVAS_COLS),
      .MAX_HEIGHT (CANVAS_ROWS)
   ) u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_func      (req_func),
      .req_filled    (req_filled),
      .req_center_x  (req_center_x),
      .req_center_y  (req_center_y),
      .req_radius    (req_radius),
      .req_draw_char (req_draw_char),
      .req_read_col  (req_read_col),
      .req_read_row  (req_read_row),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_cell_char (rsp_cell_char),
      .rsp_status    (rsp_status),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   // ---------------------------------------------------------------------
   // Shadow canvas
   // ---------------------------------------------------------------------

   // size registers: zero acts as 1, anything past the store acts as the max
   function automatic int used_cols();
      if (cfg_width == 0) return 1;
      if (cfg_width > CANVAS_COLS) return CANVAS_COLS;
      return int'(cfg_width);
   endfunction

   function automatic int used_rows();
      if (cfg_height == 0) return 1;
      if (cfg_height > CANVAS_ROWS) return CANVAS_ROWS;
      return int'(cfg_height);
   endfunction

   // Applies one accepted request to the shadow canvas and returns the word
   // the block must answer with. All distances stay in Q.16 squared units.
   function automatic cell_word_type apply_canvas_cmd(canvas_cmd_type c);
      cell_word_type word;
      longint     cx, cy, r, r2, ri, ri2, dx, dy, d2;
      longint     cols, rows;
      bit         thin;
      word.char_val = '0;
      word.status   = STATUS_OK;
      case (c.func)
         FN_CLEAR: begin
            // clear hits the whole store, not just the cells in use
            for (int i = 0; i < CANVAS_CELLS; i++) shadow_canvas[i] = cfg_bg;
         end
         FN_DRAW: begin
            if (c.radius == 0) begin
               word.status = STATUS_ZERO_RADIUS;
            end else begin
               cx   = $signed(c.center_x);
               cy   = $signed(c.center_y);
               r    = c.radius;
               r2   = r * r;
               ri   = r - Q8_ONE;
               ri2  = ri * ri;
               // sub-pixel radius: outline degenerates to the disc
               thin = (r < Q8_ONE);
               cols = used_cols();
               rows = used_rows();
               for (longint y = 0; y < rows; y++) begin
                  dy = y * Q8_ONE - cy;
                  for (longint x = 0; x < cols; x++) begin
                     dx = x * Q8_ONE - cx;
                     d2 = dx * dx + dy * dy;
                     if (d2 > r2) continue;
                     if (!c.filled && !thin && d2 <= ri2) continue;
                     shadow_canvas[y * CANVAS_COLS + x] = c.draw_char;
                  end
               end
            end
         end
         FN_READ: begin
            if (c.read_col >= used_cols() || c.read_row >= used_rows())
               word.status = STATUS_OUTSIDE;
            else
               word.char_val = shadow_canvas[c.read_row * CANVAS_COLS + c.read_col];
         end
         default: ; // unused code: no effect, zero answer
      endcase
      return word;
   endfunction

   // ---------------------------------------------------------------------
   // Request builders for the directed table
   // ---------------------------------------------------------------------

   function automatic canvas_cmd_type draw_cmd(logic fill, int cx, int cy, int r,
                                              logic [CHAR_W-1:0] ch);
      canvas_cmd_type c;
      c           = '0;
      c.func      = FN_DRAW;
      c.filled    = fill;
      c.center_x  = cx[COORD_W-1:0];
      c.center_y  = cy[COORD_W-1:0];
      c.radius    = r[RADIUS_W-1:0];
      c.draw_char = ch;
      return c;
   endfunction

   function automatic canvas_cmd_type read_cmd(int col, int row);
      canvas_cmd_type c;
      c          = '0;
      c.func     = FN_READ;
      c.read_col = col[CELL_IDX_W-1:0];
      c.read_row = row[CELL_IDX_W-1:0];
      return c;
   endfunction

   function automatic canvas_cmd_type bare_cmd(logic [FUNC_W-1:0] func);
      canvas_cmd_type c;
      c      = '0;
      c.func = func;
      return c;
   endfunction

   function automatic plan_row_type csr_step(logic [CSR_INDEX_W-1:0] idx, int val);
      plan_row_type p;
      p         = '0;
      p.kind    = PLAN_CSR;
      p.csr_idx = idx;
      p.csr_val = val[CSR_DATA_W-1:0];
      return p;
   endfunction

   function automatic plan_row_type known_step(canvas_cmd_type c,
                                               logic [CHAR_W-1:0] char_val,
                                               logic [STATUS_W-1:0] status);
      plan_row_type p;
      p               = '0;
      p.kind          = PLAN_KNOWN;
      p.cmd           = c;
      p.want.char_val = char_val;
      p.want.status   = status;
      return p;
   endfunction

   function automatic plan_row_type model_step(canvas_cmd_type c);
      plan_row_type p;
      p      = '0;
      p.kind = PLAN_MODEL;
      p.cmd  = c;
      return p;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] csr_value(int v);
      return v[CSR_DATA_W-1:0];
   endfunction

   // ---------------------------------------------------------------------
   // Random requests
   // ---------------------------------------------------------------------

   // Mostly draws near the canvas and reads inside it, so the rasterizer
   // actually hits cells; the rest is junk coordinates, huge radii, reads
   // out of range and the unused code. Clears stay out of the random mix:
   // each one walks the whole store.
   function automatic canvas_cmd_type random_canvas_cmd();
      canvas_cmd_type c;
      logic [31:0] rnd;
      int          pick, kind, cols, rows, span, tmp;
      cols = used_cols();
      rows = used_rows();
      span = ((cols > rows) ? cols : rows) / 2 + 2;
      // every field gets junk first; the chosen operation overrides some
      rnd = $urandom; c.center_x = rnd[COORD_W-1:0];
      rnd = $urandom; c.center_y = rnd[COORD_W-1:0];
      rnd = $urandom; c.radius   = rnd[RADIUS_W-1:0];
      rnd = $urandom;
      c.draw_char = rnd[CHAR_W-1:0];
      c.filled    = rnd[8];
      c.read_col  = rnd[17:9];
      c.read_row  = rnd[26:18];
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         c.func = FN_DRAW;
         if (pick < 44) begin
            tmp = $urandom_range(0, (cols + 8) * Q8_ONE) - 4 * Q8_ONE;
            c.center_x = tmp[COORD_W-1:0];
            tmp = $urandom_range(0, (rows + 8) * Q8_ONE) - 4 * Q8_ONE;
            c.center_y = tmp[COORD_W-1:0];
         end
         kind = $urandom_range(0, 9);
         if (kind == 0) begin
            c.radius = '0;
         end else if (kind == 1) begin
            tmp = $urandom_range(1, Q8_ONE - 1);
            c.radius = tmp[RADIUS_W-1:0];
         end else if (kind > 2) begin
            tmp = $urandom_range(Q8_ONE, span * Q8_ONE);
            c.radius = tmp[RADIUS_W-1:0];
         end
      end else if (pick < 92) begin
         c.func = FN_READ;
         if (pick < 86) begin
            tmp = $urandom_range(0, cols - 1);
            c.read_col = tmp[CELL_IDX_W-1:0];
            tmp = $urandom_range(0, rows - 1);
            c.read_row = tmp[CELL_IDX_W-1:0];
         end
      end else begin
         c.func = FN_UNUSED;
      end
      return c;
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Offers one word and returns in the time step of its acceptance, with
   // req_valid still high. The next call either re-drives the payload in the
   // same step (back to back) or drops valid for a gap; so valid only ever
   // gets one assignment per step.
   task automatic offer_cmd(input canvas_cmd_type c, input bit known,
                            input cell_word_type want);
      int            gap;
      cell_word_type model;
      gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_func      <= c.func;
      req_filled    <= c.filled;
      req_center_x  <= c.center_x;
      req_center_y  <= c.center_y;
      req_radius    <= c.radius;
      req_draw_char <= c.draw_char;
      req_read_col  <= c.read_col;
      req_read_row  <= c.read_row;
      do @(posedge clock); while (req_stall !== 1'b0);
      // accepted: the shadow canvas moves in acceptance order
      model = apply_canvas_cmd(c);
      awaited_words.push_back(known ? want : model);
      case (c.func)
         FN_CLEAR: clears_sent++;
         FN_DRAW: begin
            draws_sent++;
            if (model.status == STATUS_ZERO_RADIUS) zero_radius_sent++;
         end
         FN_READ: begin
            reads_sent++;
            if (model.status == STATUS_OUTSIDE) outside_sent++;
         end
         default: unused_sent++;
      endcase
   endtask

   // Register writes only happen with the block idle: every request answers
   // with exactly one word, so an empty queue means nothing is in flight.
   // After the write it waits on the clock, so that valid drops before the next call.
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      req_valid <= 1'b0;
      while (awaited_words.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      case (idx)
         CSR_CANVAS_WIDTH:    cfg_width  = val[SIZE_W-1:0];
         CSR_CANVAS_HEIGHT:   cfg_height = val[SIZE_W-1:0];
         CSR_BACKGROUND_CHAR: cfg_bg     = val[CHAR_W-1:0];
         default: ;
      endcase
      csr_writes++;
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Response side: random stall per word, one long hold-off on request
   // ---------------------------------------------------------------------
   initial begin
      int wait_cycles;
      forever begin
         if (hold_off_request) begin
            // block keeps working behind us until its output register and
            // the next result are both full, then it stalls the request side
            wait_cycles      = HOLD_OFF_CYCLES;
            hold_off_request = 1'b0;
            hold_off_done    = hold_off_done + HOLD_OFF_CYCLES;
         end else if (no_idle) begin
            wait_cycles = 0;
         end else begin
            wait_cycles = $urandom_range(0, MAX_GAP);
         end
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (reset !== 1'b0 || rsp_valid !== 1'b1);
      end
   end

   // ---------------------------------------------------------------------
   // Checker: every accepted word against the oldest expectation
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      cell_word_type want;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (awaited_words.size() == 0) begin
            $error("unexpected word: cell_char %0d status %0d",
                   rsp_cell_char, rsp_status);
            fail_count++;
         end else begin
            want = awaited_words.pop_front();
            if (rsp_cell_char !== want.char_val) begin
               $error("cell_char mismatch: expected %0d, got %0d",
                      want.char_val, rsp_cell_char);
               fail_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status mismatch: expected %0d, got %0d",
                      want.status, rsp_status);
               fail_count++;
            end
         end
      end
   end

   // Hard stop in case the block hangs
   initial begin
      #(TIMEOUT_NS);
      $display("TEST FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      plan_row_type   plan [$];
      plan_row_type   row;
      canvas_cmd_type c;
      int             counted;
      bit             hold_off_used;

      hold_off_used = 1'b0;
      cfg_width     = RESET_CANVAS_WIDTH;
      cfg_height    = RESET_CANVAS_HEIGHT;
      cfg_bg        = RESET_BACKGROUND_CHAR;

      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_func      <= FN_READ;
      req_filled    <= 1'b0;
      req_center_x  <= '0;
      req_center_y  <= '0;
      req_radius    <= '0;
      req_draw_char <= '0;
      req_read_col  <= '0;
      req_read_row  <= '0;
      csr_valid     <= 1'b0;
      csr_index     <= CSR_CANVAS_WIDTH;
      csr_data      <= '0;

      // --- directed table ---
      // reset sizes are 1x1 with a space background; the first clear is the
      // only way to see the reset background, and makes every later read legal
      plan.push_back(known_step(bare_cmd(FN_CLEAR), 8'd0, STATUS_OK));
      plan.push_back(known_step(read_cmd(0, 0), RESET_BACKGROUND_CHAR, STATUS_OK));
      plan.push_back(known_step(read_cmd(1, 0), 8'd0, STATUS_OUTSIDE));
      plan.push_back(known_step(read_cmd(0, 1), 8'd0, STATUS_OUTSIDE));
      // zero radius is flagged and paints nothing
      plan.push_back(known_step(draw_cmd(1'b1, 0, 0, 0, "Z"), 8'd0, STATUS_ZERO_RADIUS));
      plan.push_back(known_step(bare_cmd(FN_UNUSED), 8'd0, STATUS_OK));
      plan.push_back(known_step(draw_cmd(1'b1, 0, 0, Q8_ONE, "A"), 8'd0, STATUS_OK));
      plan.push_back(model_step(read_cmd(0, 0)));
      // widest canvas, one row: ring of radius 100 around column 256
      plan.push_back(csr_step(CSR_CANVAS_WIDTH, 512));
      plan.push_back(known_step(draw_cmd(1'b0, 256 * Q8_ONE, 0, 100 * Q8_ONE, "o"),
                                8'd0, STATUS_OK));
      plan.push_back(model_step(read_cmd(156, 0)));   // on the rim
      plan.push_back(model_step(read_cmd(256, 0)));   // hollow centre
      plan.push_back(model_step(read_cmd(511, 0)));
      plan.push_back(known_step(read_cmd(511, 1), 8'd0, STATUS_OUTSIDE));
      // tallest canvas, one column: largest radius, 0xFF paint
      plan.push_back(csr_step(CSR_CANVAS_WIDTH, 1));
      plan.push_back(csr_step(CSR_CANVAS_HEIGHT, 512));
      plan.push_back(known_step(draw_cmd(1'b1, 0, 511 * Q8_ONE + 128, 524287, 8'hFF),
                                8'd0, STATUS_OK));
      plan.push_back(model_step(read_cmd(0, 511)));
      plan.push_back(known_step(read_cmd(1, 511), 8'd0, STATUS_OUTSIDE));
      // out-of-range sizes: width 0 acts as 1, height 1023 as the max
      plan.push_back(csr_step(CSR_CANVAS_WIDTH, 0));
      plan.push_back(csr_step(CSR_CANVAS_HEIGHT, 1023));
      // sub-pixel outline paints like a disc; paint char 0
      plan.push_back(known_step(draw_cmd(1'b0, 0, 3 * Q8_ONE, 128, 8'h00), 8'd0, STATUS_OK));
      plan.push_back(model_step(read_cmd(0, 3)));
      // centre at the coordinate extremes
      plan.push_back(known_step(draw_cmd(1'b0, -524288, 524287, 524287, "x"),
                                8'd0, STATUS_OK));
      plan.push_back(model_step(read_cmd(0, 511)));
      // 8x8 canvas, second clear with background 0xFF
      plan.push_back(csr_step(CSR_CANVAS_WIDTH, 8));
      plan.push_back(csr_step(CSR_CANVAS_HEIGHT, 8));
      plan.push_back(csr_step(CSR_BACKGROUND_CHAR, 255));
      plan.push_back(known_step(bare_cmd(FN_CLEAR), 8'd0, STATUS_OK));
      plan.push_back(known_step(read_cmd(7, 7), 8'hFF, STATUS_OK));
      plan.push_back(known_step(read_cmd(8, 0), 8'd0, STATUS_OUTSIDE));
      plan.push_back(known_step(read_cmd(0, 8), 8'd0, STATUS_OUTSIDE));
      plan.push_back(known_step(draw_cmd(1'b0, 896, 896, 3 * Q8_ONE, "#"),
                                8'd0, STATUS_OK));
      plan.push_back(model_step(read_cmd(0, 3)));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         row = plan[i];
         if (row.kind == PLAN_CSR) write_csr(row.csr_idx, row.csr_val);
         else offer_cmd(row.cmd, row.kind == PLAN_KNOWN, row.want);
      end

      // --- random phases, each at its own canvas size ---
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            1: begin
               // full-width strip of one or two rows, no idling anywhere
               write_csr(CSR_CANVAS_WIDTH, 10'd1023);
               write_csr(CSR_CANVAS_HEIGHT, csr_value($urandom_range(0, 2)));
               no_idle = 1'b1;
            end
            2: begin
               // narrow full-height column, background back to 0
               write_csr(CSR_CANVAS_WIDTH, csr_value($urandom_range(0, 3)));
               write_csr(CSR_CANVAS_HEIGHT, 10'd1023);
               write_csr(CSR_BACKGROUND_CHAR, 10'd0);
            end
            default: begin
               write_csr(CSR_CANVAS_WIDTH, csr_value($urandom_range(1, 24)));
               write_csr(CSR_CANVAS_HEIGHT, csr_value($urandom_range(1, 24)));
            end
         endcase
         counted = 0;
         while (counted < ITEMS_PER_PHASE) begin
            c = random_canvas_cmd();
            // last phase: receiver holds off once while we keep offering
            if (p == RANDOM_PHASES - 1 && counted == 8 && !hold_off_used) begin
               hold_off_request = 1'b1;
               hold_off_used    = 1'b1;
            end
            offer_cmd(c, 1'b0, '0);
            if (c.func != FN_UNUSED) counted++;
         end
         no_idle = 1'b0;
      end

      // --- drain ---
      req_valid <= 1'b0;
      while (awaited_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d clears, %0d draws (%0d with zero radius), %0d reads",
               clears_sent, draws_sent, zero_radius_sent, reads_sent);
      $display("  (%0d outside canvas), %0d unused codes, %0d register writes,",
               outside_sent, unused_sent, csr_writes);
      $display("  %0d hold-off cycles", hold_off_done);
      if (fail_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule
